### rtl/core/hml_pkg.sv
// ----------------------------------------------------------------------------
// hml_pkg
// Shared types and constants of the HTML markup tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package hml_pkg;

    localparam int PeekBytes = 8;
    localparam int PatLen    = 7;
    localparam int QueueSize = 4;

    localparam logic [3:0] K_TEXT         = 4'd0;
    localparam logic [3:0] K_WS           = 4'd1;
    localparam logic [3:0] K_TAGOPEN      = 4'd2;
    localparam logic [3:0] K_CLOSETAGOPEN = 4'd3;
    localparam logic [3:0] K_TAGCLOSE     = 4'd4;
    localparam logic [3:0] K_SELFCLOSE    = 4'd5;
    localparam logic [3:0] K_EQUAL        = 4'd6;
    localparam logic [3:0] K_DQUOTE       = 4'd7;
    localparam logic [3:0] K_SQUOTE       = 4'd8;
    localparam logic [3:0] K_ESCAPE       = 4'd9;
    localparam logic [3:0] K_COMMENTOPEN  = 4'd10;
    localparam logic [3:0] K_COMMENTCLOSE = 4'd11;
    localparam logic [3:0] K_CDATAOPEN    = 4'd12;
    localparam logic [3:0] K_CDATACLOSE   = 4'd13;
    localparam logic [3:0] K_DOCTYPE      = 4'd14;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [3:0] {
        M_TEXT = 4'b0001,
        M_WS   = 4'b0010,
        M_TAG  = 4'b0100,
        M_BANG = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        GO_ON   = 2'd0,
        GO_WAIT = 2'd1,
        GO_STOP = 2'd2
    } go_t;

    typedef struct packed {
        logic       e0_en;
        logic [3:0] e0_kind;
        logic       e1_en;
        logic [3:0] e1_kind;
        logic [3:0] take;
        mode_t      mode_next;
        go_t        go;
    } step_t;

    function automatic logic [7:0] pat_cdata(input logic [2:0] i);
        case (i)
            3'd0:    pat_cdata = 8'h5B;
            3'd1:    pat_cdata = 8'h43;
            3'd2:    pat_cdata = 8'h44;
            3'd3:    pat_cdata = 8'h41;
            3'd4:    pat_cdata = 8'h54;
            3'd5:    pat_cdata = 8'h41;
            3'd6:    pat_cdata = 8'h5B;
            default: pat_cdata = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] pat_doctype(input logic [2:0] i);
        case (i)
            3'd0:    pat_doctype = 8'h64;
            3'd1:    pat_doctype = 8'h6F;
            3'd2:    pat_doctype = 8'h63;
            3'd3:    pat_doctype = 8'h74;
            3'd4:    pat_doctype = 8'h79;
            3'd5:    pat_doctype = 8'h70;
            3'd6:    pat_doctype = 8'h65;
            default: pat_doctype = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

### rtl/core/hml_step.sv
// ----------------------------------------------------------------------------
// hml_step
// One lexer step: decides tokens, bytes taken and next mode from the head
// of the lookahead buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module hml_step (
    input  hml_pkg::mode_t          mode,
    input  logic [7:0]              peek [hml_pkg::PeekBytes],
    input  logic [3:0]              cnt,
    input  logic                    fin,
    input  logic                    at_start,
    output hml_pkg::step_t          step
);
    import hml_pkg::*;

    logic       flush;
    logic       pat_done;
    logic       pat_wait;
    logic       pat_fail;
    logic       doc;
    logic [7:0] c;

    always_comb
    begin
        step           = '0;
        step.mode_next = mode;
        step.go        = GO_ON;
        flush          = 1'b0;
        pat_done       = 1'b0;
        pat_wait       = 1'b0;
        pat_fail       = 1'b0;
        doc            = (peek[1] != CH_LBRK);
        c              = 8'h00;
        case (mode)
            M_WS:
            begin
                if (cnt == 4'd0)
                begin
                    if (!fin)
                        step.go = GO_WAIT;
                    else
                    begin
                        step.e0_en   = 1'b1;
                        step.e0_kind = K_WS;
                        step.go      = GO_STOP;
                    end
                end
                else if (is_ws(peek[0]))
                    step.take = 4'd1;
                else
                begin
                    step.e0_en     = 1'b1;
                    step.e0_kind   = K_WS;
                    step.mode_next = M_TEXT;
                end
            end
            M_TAG:
            begin
                if (cnt == 4'd0)
                begin
                    if (!fin)
                        step.go = GO_WAIT;
                    else
                    begin
                        step.e0_en   = 1'b1;
                        step.e0_kind = K_TAGOPEN;
                        step.go      = GO_STOP;
                    end
                end
                else if (peek[0] == CH_BANG)
                    step.mode_next = M_BANG;
                else if (peek[0] == CH_SLASH)
                begin
                    step.take      = 4'd1;
                    step.e1_en     = 1'b1;
                    step.e1_kind   = K_CLOSETAGOPEN;
                    step.mode_next = M_TEXT;
                end
                else
                begin
                    step.e0_en     = 1'b1;
                    step.e0_kind   = K_TAGOPEN;
                    step.mode_next = M_TEXT;
                end
            end
            M_BANG:
            begin
                if (cnt < 4'd2)
                begin
                    if (!fin)
                        step.go = GO_WAIT;
                    else
                    begin
                        step.e0_en   = 1'b1;
                        step.e0_kind = K_TAGOPEN;
                        step.take    = 4'd1;
                        step.e1_en   = 1'b1;
                        step.e1_kind = K_TEXT;
                        step.go      = GO_STOP;
                    end
                end
                else if (peek[1] == CH_DASH)
                begin
                    if (cnt < 4'd3)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                            pat_fail = 1'b1;
                    end
                    else if (peek[2] != CH_DASH)
                        pat_fail = 1'b1;
                    else
                    begin
                        step.take      = 4'd3;
                        step.e1_en     = 1'b1;
                        step.e1_kind   = K_COMMENTOPEN;
                        step.mode_next = M_TEXT;
                    end
                end
                else if (peek[1] == CH_LBRK || fold(peek[1]) == CH_D)
                begin
                    for (int i = 0; i < PatLen; i++)
                    begin
                        if (!pat_done)
                        begin
                            if (4'(i + 1) >= cnt)
                            begin
                                pat_done = 1'b1;
                                pat_wait = 1'b1;
                            end
                            else if (doc ? (fold(peek[i + 1]) != pat_doctype(3'(i)))
                                         : (peek[i + 1] != pat_cdata(3'(i))))
                            begin
                                pat_done = 1'b1;
                                pat_fail = 1'b1;
                            end
                        end
                    end
                    if (pat_wait)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                            pat_fail = 1'b1;
                    end
                    else if (!pat_fail)
                    begin
                        step.take      = 4'd8;
                        step.e1_en     = 1'b1;
                        step.e1_kind   = doc ? K_DOCTYPE : K_CDATAOPEN;
                        step.mode_next = M_TEXT;
                    end
                end
                else
                    pat_fail = 1'b1;
                if (pat_fail)
                begin
                    step.e0_en     = 1'b1;
                    step.e0_kind   = K_TAGOPEN;
                    step.mode_next = M_TEXT;
                end
            end
            default:
            begin
                step.mode_next = M_TEXT;
                c              = peek[0];
                if (cnt == 4'd0)
                begin
                    if (!fin)
                        step.go = GO_WAIT;
                    else
                    begin
                        flush   = 1'b1;
                        step.go = GO_STOP;
                    end
                end
                else if (c == CH_LT)
                begin
                    flush          = 1'b1;
                    step.take      = 4'd1;
                    step.mode_next = M_TAG;
                end
                else if (c == CH_SLASH)
                begin
                    if (cnt < 4'd2)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                            step.take = 4'd1;
                    end
                    else if (peek[1] == CH_GT)
                    begin
                        flush        = 1'b1;
                        step.take    = 4'd2;
                        step.e1_en   = 1'b1;
                        step.e1_kind = K_SELFCLOSE;
                    end
                    else
                        step.take = 4'd1;
                end
                else if (c == CH_GT || c == CH_EQ || c == CH_DQ || c == CH_SQ)
                begin
                    flush        = 1'b1;
                    step.take    = 4'd1;
                    step.e1_en   = 1'b1;
                    step.e1_kind = (c == CH_GT) ? K_TAGCLOSE :
                                   (c == CH_EQ) ? K_EQUAL :
                                   (c == CH_DQ) ? K_DQUOTE : K_SQUOTE;
                end
                else if (c == CH_BSL)
                begin
                    if (cnt < 4'd2)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                        begin
                            flush        = 1'b1;
                            step.take    = 4'd1;
                            step.e1_en   = 1'b1;
                            step.e1_kind = K_ESCAPE;
                            step.go      = GO_STOP;
                        end
                    end
                    else
                    begin
                        flush        = 1'b1;
                        step.take    = 4'd2;
                        step.e1_en   = 1'b1;
                        step.e1_kind = K_ESCAPE;
                    end
                end
                else if (c == CH_DASH || c == CH_RBRK)
                begin
                    if (cnt < 4'd2)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                            step.take = 4'd1;
                    end
                    else if (peek[1] != c)
                        step.take = 4'd1;
                    else if (cnt < 4'd3)
                    begin
                        if (!fin)
                            step.go = GO_WAIT;
                        else
                            step.take = 4'd1;
                    end
                    else if (peek[2] == CH_GT)
                    begin
                        flush        = 1'b1;
                        step.take    = 4'd3;
                        step.e1_en   = 1'b1;
                        step.e1_kind = (c == CH_DASH) ? K_COMMENTCLOSE : K_CDATACLOSE;
                    end
                    else
                        step.take = 4'd1;
                end
                else if (is_ws(c))
                begin
                    flush          = 1'b1;
                    step.mode_next = M_WS;
                end
                else
                    step.take = 4'd1;
                if (flush && !at_start)
                begin
                    step.e0_en   = 1'b1;
                    step.e0_kind = K_TEXT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/hml_tokq.sv
// ----------------------------------------------------------------------------
// hml_tokq
// Token queue: collects the tokens of one byte, then sends them out.
// ----------------------------------------------------------------------------
`default_nettype none

module hml_tokq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr,
    input  logic        push0,
    input  logic [3:0]  kind0,
    input  logic [31:0] beg0,
    input  logic [31:0] end0,
    input  logic        push1,
    input  logic [3:0]  kind1,
    input  logic [31:0] beg1,
    input  logic [31:0] end1,
    input  logic        send,
    input  logic        fin,
    output logic        done,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // token_kind, token_begin, token_end, pad
    output logic        m_axis_tlast,   // run_last
    output logic [0:0]  m_axis_tuser    // stream_done
);
    import hml_pkg::*;

    logic [3:0]  q_kind [QueueSize];
    logic [31:0] q_beg  [QueueSize];
    logic [31:0] q_end  [QueueSize];
    logic [2:0]  qn_reg, qn_next;
    logic [1:0]  rd_reg, rd_next;
    logic        empty;
    logic        last;
    logic        ok0;
    logic        ok1;

    assign ok0 = push0 && (qn_reg < 3'(QueueSize));
    assign ok1 = push1 && ((qn_reg + 3'(ok0)) < 3'(QueueSize));

    always_ff @(posedge clk)
    begin
        if (ok0)
        begin
            q_kind[qn_reg[1:0]] <= kind0;
            q_beg[qn_reg[1:0]]  <= beg0;
            q_end[qn_reg[1:0]]  <= end0;
        end
        if (ok1)
        begin
            q_kind[2'(qn_reg + 3'(ok0))] <= kind1;
            q_beg[2'(qn_reg + 3'(ok0))]  <= beg1;
            q_end[2'(qn_reg + 3'(ok0))]  <= end1;
        end
    end

    assign empty = (qn_reg == 3'd0);
    assign last  = ({1'b0, rd_reg} == qn_reg - 3'd1);
    assign m_axis_tvalid = send && !empty;
    assign m_axis_tdata  = {4'd0, q_end[rd_reg], q_beg[rd_reg], q_kind[rd_reg]};
    assign m_axis_tlast  = last;
    assign m_axis_tuser  = fin && last;
    assign done = send && (empty || (m_axis_tready && last));

    always_comb
    begin
        qn_next = qn_reg + 3'(ok0) + 3'(ok1);
        rd_next = rd_reg;
        if (m_axis_tvalid && m_axis_tready)
            rd_next = rd_reg + 2'd1;
        if (clr)
        begin
            qn_next = 3'd0;
            rd_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qn_reg <= 3'd0;
            rd_reg <= 2'd0;
        end
        else
        begin
            qn_reg <= qn_next;
            rd_reg <= rd_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/html_markup_tokenizer.sv
// ----------------------------------------------------------------------------
// html_markup_tokenizer
// Streaming HTML lexer: bytes in, tokens with begin and end offsets out.
// ----------------------------------------------------------------------------
// Flow: a byte is taken in idle, then the single step unit runs lexer
// steps until it must wait for more bytes, stops or hits a step guard,
// then the token queue sends its tokens. No new byte is taken until the
// tokens of the last one are sent.
// Reset and the final byte return the mode to text, and offsets and buffer fill to zero.
`default_nettype none

module html_markup_tokenizer #(
    parameter int OFFSET_BITS     = 32,
    parameter int LOOKAHEAD_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // token_kind, token_begin, token_end, pad
    output logic        m_axis_tlast,   // run_last
    output logic [0:0]  m_axis_tuser    // stream_done
);
    import hml_pkg::*;

    localparam int CNT_W   = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int GUARD   = 4 * LOOKAHEAD_DEPTH + 16;
    localparam int GUARD_W = $clog2(GUARD);
    localparam int LOW_W   = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [GUARD_W-1:0]     guard_reg, guard_next;
    logic                   fin_reg, fin_next;
    logic [7:0]             buf_reg [LOOKAHEAD_DEPTH];
    logic [7:0]             buf_next [LOOKAHEAD_DEPTH];
    logic [7:0]             peek [PeekBytes];
    logic [3:0]             cnt_sat;
    logic [3:0]             take;
    logic [OFFSET_BITS-1:0] pos_adv;
    step_t                  step;
    logic                   run;
    logic                   q_done;
    logic                   accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign run           = (state_reg == ST_RUN);
    assign cnt_sat       = (cnt_reg > CNT_W'(PeekBytes)) ? 4'(PeekBytes) : 4'(cnt_reg);

    always_comb
    begin
        for (int i = 0; i < PeekBytes; i++)
            peek[i] = buf_reg[i];
    end

    hml_step u_step (
        .mode     (mode_reg),
        .peek     (peek),
        .cnt      (cnt_sat),
        .fin      (fin_reg),
        .at_start (pos_reg == start_reg),
        .step     (step)
    );

    assign take    = (step.take > cnt_sat) ? cnt_sat : step.take;
    assign pos_adv = pos_reg + OFFSET_BITS'(take);

    hml_tokq u_tokq (
        .clk           (clk),
        .rst_n         (rst_n),
        .clr           (q_done),
        .push0         (run && step.e0_en),
        .kind0         (step.e0_kind),
        .beg0          (32'(start_reg[LOW_W-1:0])),
        .end0          (32'(pos_reg[LOW_W-1:0])),
        .push1         (run && step.e1_en),
        .kind1         (step.e1_kind),
        .beg1          (step.e0_en ? 32'(pos_reg[LOW_W-1:0]) : 32'(start_reg[LOW_W-1:0])),
        .end1          (32'(pos_adv[LOW_W-1:0])),
        .send          (state_reg == ST_SEND),
        .fin           (fin_reg),
        .done          (q_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        guard_next = guard_reg;
        fin_next   = fin_reg;
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++)
            buf_next[i] = buf_reg[i];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next   = s_axis_tlast;
                    guard_next = '0;
                    state_next = ST_RUN;
                    if (cnt_reg < CNT_W'(LOOKAHEAD_DEPTH))
                    begin
                        buf_next[cnt_reg[$clog2(LOOKAHEAD_DEPTH)-1:0]] = s_axis_tdata;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                mode_next  = step.mode_next;
                pos_next   = pos_adv;
                start_next = step.e1_en ? pos_adv : (step.e0_en ? pos_reg : start_reg);
                cnt_next   = cnt_reg - CNT_W'(take);
                for (int i = 0; i < LOOKAHEAD_DEPTH; i++)
                begin
                    for (int j = 1; j <= PeekBytes; j++)
                    begin
                        if (take == 4'(j))
                            buf_next[i] = (i + j < LOOKAHEAD_DEPTH) ? buf_reg[i + j] : 8'h00;
                    end
                end
                guard_next = guard_reg + 1'b1;
                if (step.go != GO_ON || guard_reg == GUARD_W'(GUARD - 1))
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (q_done)
                begin
                    state_next = ST_IDLE;
                    if (fin_reg)
                    begin
                        mode_next  = M_TEXT;
                        pos_next   = '0;
                        start_next = '0;
                        cnt_next   = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++)
            buf_reg[i] <= buf_next[i];
        guard_reg <= guard_next;
        fin_reg   <= fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= M_TEXT;
            pos_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire
